>>> hdl/assert_macros.svh
// assertion macros used by the sampler top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/kvts_pkg.sv
// types and constants for the vec3 keyframe track sampler
// used by kvts_front, kvts_back and the top level; no dependencies
package kvts_pkg;

   localparam int unsigned VAL_W  = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned SLOT_W = 6;
   localparam int unsigned KC_W   = 7;
   localparam int unsigned FAC_W  = 17;
   localparam int unsigned SEG_W  = 6;
   localparam int unsigned QUO_W  = 16;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [FAC_W-1:0] FAC_ONE = 17'h10000;

   typedef struct packed {
      logic              is_load;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] tval;   // key time for loads, query time for samples
      logic [VAL_W-1:0]  x;
      logic [VAL_W-1:0]  y;
      logic [VAL_W-1:0]  z;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_LO,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } back_state_type;

endpackage

>>> hdl/keyframe_vec3_track_sampler_core.sv
// vec3 keyframe track sampler, usage notes:
// req channel carries one transaction per command. tuser = command
// (0 load key, 1 sample). a load writes key_time and key_x/y/z into
// key_slot and gives no response; a sample returns one rsp transaction
// with the linearly interpolated vec3, the blend factor and the segment.
// csr channel writes key_count (keys in the track, 0 and 1 mean one key);
// write it only while no transaction is in flight.
// a load is written into the key stores straight from the idle state. a
// sample reaching an idle back end passes a linear search over the segments
// (one store read per cycle), the serial factor divider and the shared
// multiplier before it shows rsp_tvalid; a factor of zero or one skips the
// divider, and a single-key track skips both the search and the divider.
// a 2-entry queue between front and back keeps req accepting while the
// back end works; a stalled rsp holds its result and blocks the next one.
// reset (synchronous, active high) empties the queue, drops any pending
// response and sets key_count to 1; key stores are not cleared.
// depends on kvts_pkg, kvts_front, kvts_back and assert_macros.svh
`include "assert_macros.svh"

module keyframe_vec3_track_sampler_core import kvts_pkg::*; #(
   parameter int unsigned MAX_KEYS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // key_slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
   // key_z[133:102], sample_time[165:134], zero fill
   input  logic [167:0] req_tdata,
   // command
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], blend_factor[112:96],
   // segment[118:113], zero fill
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);

   qhead_type         head;
   logic              pop;
   logic [KC_W-1:0]   key_count_ff, key_count_in;
   logic [VAL_W-1:0]  rsp_x, rsp_y, rsp_z;
   logic [FAC_W-1:0]  rsp_fac;
   logic [SEG_W-1:0]  rsp_seg;

   assign csr_ready    = 1'b1;
   assign key_count_in = (csr_valid && csr_ready) ? csr_data : key_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KC_W'(1);
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   kvts_front #(.MAX_KEYS(MAX_KEYS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .command     (req_tuser),
      .key_slot    (req_tdata[5:0]),
      .key_time    (req_tdata[37:6]),
      .key_x       (req_tdata[69:38]),
      .key_y       (req_tdata[101:70]),
      .key_z       (req_tdata[133:102]),
      .sample_time (req_tdata[165:134]),
      .head        (head),
      .pop         (pop)
   );

   kvts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .key_count (key_count_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_z     (rsp_z),
      .rsp_fac   (rsp_fac),
      .rsp_seg   (rsp_seg)
   );

   assign rsp_tdata = {1'b0, rsp_seg, rsp_fac, rsp_z, rsp_y, rsp_x};

   // the factor never leaves [0, one]
   `ASSERT_IMPLY(a_fac_range, clock, reset, rsp_tvalid, rsp_fac <= FAC_ONE)
   // nothing is presented right after reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid)
   // the back end never pops an empty queue
   `ASSERT_IMPLY(a_pop_valid, clock, reset, pop, head.valid)

endmodule

>>> hdl/kvts_front.sv
// input side of the sampler: accepts transactions, classifies them and
// queues them for the back end; depends on kvts_pkg
module kvts_front import kvts_pkg::*; #(
   parameter int unsigned MAX_KEYS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              command,
   input  logic [SLOT_W-1:0] key_slot,
   input  logic [TIME_W-1:0] key_time,
   input  logic [VAL_W-1:0]  key_x,
   input  logic [VAL_W-1:0]  key_y,
   input  logic [VAL_W-1:0]  key_z,
   input  logic [TIME_W-1:0] sample_time,
   output qhead_type         head,
   input  logic              pop
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item;
   logic       push;
   logic       drop;

   assign req_tready = (cnt_ff != 2'd2);

   always_comb begin
      item.is_load = (command == CMD_LOAD);
      item.slot    = key_slot;
      item.tval    = item.is_load ? key_time : sample_time;
      item.x       = key_x;
      item.y       = key_y;
      item.z       = key_z;
      // loads past the store depth are swallowed here
      drop = item.is_load && (32'(key_slot) >= MAX_KEYS);
      push = req_tvalid && req_tready && !drop;
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop && head.valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !(pop && head.valid)) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop && head.valid) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> hdl/kvts_back.sv
// back end of the sampler: key stores, segment search, serial divider
// and shared multiplier, output register; depends on kvts_pkg
module kvts_back import kvts_pkg::*; #(
   parameter int unsigned MAX_KEYS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  qhead_type         head,
   output logic              pop,
   input  logic [KC_W-1:0]   key_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [VAL_W-1:0]  rsp_x,
   output logic [VAL_W-1:0]  rsp_y,
   output logic [VAL_W-1:0]  rsp_z,
   output logic [FAC_W-1:0]  rsp_fac,
   output logic [SEG_W-1:0]  rsp_seg
);

   localparam int unsigned AW = $clog2(MAX_KEYS);

   logic [TIME_W-1:0] time_mem [MAX_KEYS];
   logic [VAL_W-1:0]  x_mem    [MAX_KEYS];
   logic [VAL_W-1:0]  y_mem    [MAX_KEYS];
   logic [VAL_W-1:0]  z_mem    [MAX_KEYS];

   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TIME_W-1:0] rd_t_ff;
   logic [VAL_W-1:0]  rd_v_ff [3];

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [AW-1:0]     seg_ff, seg_in;
   logic              single_ff, single_in;
   logic [TIME_W-1:0] tq_ff, tq_in;
   logic [TIME_W-1:0] t1_ff, t1_in;
   logic [VAL_W-1:0]  v0_ff [3];
   logic [VAL_W-1:0]  v0_in [3];
   logic [VAL_W-1:0]  v1_ff [3];
   logic [VAL_W-1:0]  v1_in [3];
   logic [VAL_W-1:0]  res_ff [3];
   logic [VAL_W-1:0]  res_in [3];
   logic signed [32:0] num_ff, num_in;
   logic signed [32:0] den_ff, den_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [FAC_W-1:0]  fac_ff, fac_in;
   logic [1:0]        comp_ff, comp_in;
   logic signed [50:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [FAC_W-1:0]  rsp_fac_ff;
   logic [SEG_W-1:0]  rsp_seg_ff;
   logic              rsp_load;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= head.item.tval;
         x_mem[wr_addr]    <= head.item.x;
         y_mem[wr_addr]    <= head.item.y;
         z_mem[wr_addr]    <= head.item.z;
      end
      rd_t_ff    <= time_mem[rd_addr];
      rd_v_ff[0] <= x_mem[rd_addr];
      rd_v_ff[1] <= y_mem[rd_addr];
      rd_v_ff[2] <= z_mem[rd_addr];
   end

   assign wr_addr = AW'(head.item.slot);

   always_comb begin
      logic              nneg;
      logic              dneg;
      logic [32:0]       nabs;
      logic [32:0]       dabs;
      logic [32:0]       r2;
      logic              qbit;
      logic [QUO_W-1:0]  qnext;
      logic signed [50:0] diff_w;
      logic signed [50:0] fac_w;
      logic signed [50:0] adj;
      logic signed [50:0] shr;
      logic [1:0]        k;

      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      seg_in       = seg_ff;
      single_in    = single_ff;
      tq_in        = tq_ff;
      t1_in        = t1_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      res_in       = res_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      fac_in       = fac_ff;
      comp_in      = comp_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_load     = 1'b0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = idx_ff;
      nneg         = num_ff[32];
      dneg         = den_ff[32];
      nabs         = nneg ? 33'(-num_ff) : 33'(num_ff);
      dabs         = dneg ? 33'(-den_ff) : 33'(den_ff);
      r2           = {rem_ff, 1'b0};
      qbit         = (r2 >= {1'b0, dvs_ff});
      qnext        = {quo_ff[QUO_W-2:0], qbit};
      diff_w       = '0;
      fac_w        = 51'($signed({1'b0, fac_ff}));
      adj          = prod_ff + (prod_ff[50] ? 51'sd65535 : 51'sd0);
      shr          = adj >>> 16;
      k            = comp_ff - 2'd1;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.is_load) begin
                  wr_en = 1'b1;
               end else begin
                  tq_in = head.item.tval;
                  if (key_count <= KC_W'(1)) begin
                     single_in = 1'b1;
                     seg_in    = '0;
                     rd_addr   = '0;
                     state_in  = ST_LO;
                  end else begin
                     if (32'(key_count) > MAX_KEYS) begin
                        last_in = AW'(MAX_KEYS - 1);
                     end else begin
                        last_in = AW'(32'(key_count) - 32'd1);
                     end
                     single_in = 1'b0;
                     idx_in    = '0;
                     rd_addr   = AW'(1);
                     state_in  = ST_SRCH;
                  end
               end
            end
         end
         ST_SRCH: begin
            // upper key of segment idx sits in the read registers
            if ((tq_ff < rd_t_ff) || ((idx_ff + AW'(1)) == last_ff)) begin
               t1_in    = rd_t_ff;
               v1_in    = rd_v_ff;
               seg_in   = idx_ff;
               rd_addr  = idx_ff;
               state_in = ST_LO;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(2);
            end
         end
         ST_LO: begin
            v0_in = rd_v_ff;
            if (single_ff) begin
               v1_in    = rd_v_ff;
               fac_in   = '0;
               comp_in  = '0;
               state_in = ST_MUL;
            end else begin
               num_in   = $signed({1'b0, tq_ff}) - $signed({1'b0, rd_t_ff});
               den_in   = $signed({1'b0, t1_ff}) - $signed({1'b0, rd_t_ff});
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            comp_in = '0;
            // opposite signs truncate to zero or below, which clamps to zero
            if ((den_ff == '0) || (num_ff == '0) || (nneg != dneg)) begin
               fac_in   = '0;
               state_in = ST_MUL;
            end else if (nabs >= dabs) begin
               fac_in   = FAC_ONE;
               state_in = ST_MUL;
            end else begin
               rem_in   = nabs[31:0];
               dvs_in   = dabs[31:0];
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (qbit) begin
               rem_in = 32'(r2 - {1'b0, dvs_ff});
            end else begin
               rem_in = r2[31:0];
            end
            quo_in = qnext;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               fac_in   = {1'b0, qnext};
               comp_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // product of one component while the previous one is finished
            if (comp_ff != 2'd3) begin
               diff_w  = 51'($signed(v1_ff[comp_ff])) - 51'($signed(v0_ff[comp_ff]));
               prod_in = diff_w * fac_w;
            end
            if (comp_ff != 2'd0) begin
               res_in[k] = v0_ff[k] + shr[31:0];
            end
            if (comp_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      seg_ff    <= seg_in;
      single_ff <= single_in;
      tq_ff     <= tq_in;
      t1_ff     <= t1_in;
      v0_ff     <= v0_in;
      v1_ff     <= v1_in;
      res_ff    <= res_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      fac_ff    <= fac_in;
      comp_ff   <= comp_in;
      prod_ff   <= prod_in;
      if (rsp_load) begin
         rsp_x_ff   <= res_ff[0];
         rsp_y_ff   <= res_ff[1];
         rsp_z_ff   <= res_ff[2];
         rsp_fac_ff <= fac_ff;
         rsp_seg_ff <= SEG_W'(seg_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x     = rsp_x_ff;
   assign rsp_y     = rsp_y_ff;
   assign rsp_z     = rsp_z_ff;
   assign rsp_fac   = rsp_fac_ff;
   assign rsp_seg   = rsp_seg_ff;

endmodule
